// File: design/mck_pkg.sv
package mck_pkg;

  localparam int unsigned MckCmdDepth = 2;

  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CaseMask   = 8'h5F;
  localparam logic [7:0] LetterA    = 8'h41;
  localparam logic [7:0] LetterZ    = 8'h5A;

  localparam logic [2:0] DurNone    = 3'd0;
  localparam logic [2:0] DurDot     = 3'd1;
  localparam logic [2:0] DurDash    = 3'd3;
  localparam logic [2:0] DurLetter  = 3'd3;
  localparam logic [2:0] DurWord    = 3'd7;

  typedef enum logic [2:0] {
    SymNone,
    SymDot,
    SymDash,
    SymOneSpace,
    SymTwoSpaces,
    SymNewline
  } sym_e;

  typedef enum logic [1:0] {
    GapNone,
    GapLetter,
    GapWord
  } gap_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkGap,
    BkElems,
    BkNewline
  } back_state_e;

  typedef struct packed {
    logic        newline;
    gap_e        gap;
    logic [15:0] pattern;
  } cmd_t;

  function automatic logic [15:0] letter_pattern(input logic [4:0] idx);
    logic [15:0] pat;
    case (idx)
      5'd0:    pat = 16'hB800;
      5'd1:    pat = 16'hEA80;
      5'd2:    pat = 16'hEBA0;
      5'd3:    pat = 16'hEA00;
      5'd4:    pat = 16'h8000;
      5'd5:    pat = 16'hAE80;
      5'd6:    pat = 16'hEE80;
      5'd7:    pat = 16'hAA00;
      5'd8:    pat = 16'hA000;
      5'd9:    pat = 16'hBBB8;
      5'd10:   pat = 16'hEB80;
      5'd11:   pat = 16'hBA80;
      5'd12:   pat = 16'hEE00;
      5'd13:   pat = 16'hE800;
      5'd14:   pat = 16'hEEE0;
      5'd15:   pat = 16'hBBA0;
      5'd16:   pat = 16'hEEB8;
      5'd17:   pat = 16'hBA00;
      5'd18:   pat = 16'hA800;
      5'd19:   pat = 16'hE000;
      5'd20:   pat = 16'hAE00;
      5'd21:   pat = 16'hAB80;
      5'd22:   pat = 16'hBB80;
      5'd23:   pat = 16'hEAE0;
      5'd24:   pat = 16'hEBB8;
      5'd25:   pat = 16'hEEA0;
      default: pat = 16'h0000;
    endcase
    return pat;
  endfunction

endpackage

// File: design/morse_code_keyer_unit.sv
// A request's first segment passes the command queue, the sequencer and the result register.
// The sequencer emits one segment per cycle while the result register is empty or popped,
// and fetches each command from the queue in its idle state before emitting its segments.
// Spaces and skipped bytes are taken by the front end and produce no command.
// Reset clears the spacing flags, the command queue, the sequencer state and the result valid flag.
module morse_code_keyer_unit
  import mck_pkg::*;
#(
  parameter int unsigned CmdDepth = MckCmdDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       action_i,
  input  logic [7:0] char_code_i,
  output logic       empty,
  input  logic       pop,
  output logic       led_on_o,
  output logic [2:0] duration_units_o,
  output logic [2:0] text_symbol_o,
  output logic       last_o
);

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_out;

  assign full = cmd_full;

  mck_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_full_i  (cmd_full),
    .action_i    (action_i),
    .char_code_i (char_code_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  mck_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  mck_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_empty_i      (cmd_empty),
    .cmd_i            (cmd_out),
    .cmd_pop_o        (cmd_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .led_on_o         (led_on_o),
    .duration_units_o (duration_units_o),
    .text_symbol_o    (text_symbol_o),
    .last_o           (last_o)
  );

endmodule

// File: design/mck_front.sv
module mck_front
  import mck_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       cmd_full_i,
  input  logic       action_i,
  input  logic [7:0] char_code_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  logic       pend_q, pend_d;
  logic       space_q, space_d;
  logic       sent_q, sent_d;
  logic       accept;
  logic [7:0] masked;
  logic       is_letter;
  logic [4:0] idx;

  assign accept = push_i && !cmd_full_i;
  assign masked = char_code_i & CaseMask;
  assign idx    = 5'(masked - LetterA);

  always_comb begin
    is_letter = masked inside {[LetterA:LetterZ]};
  end

  always_comb begin
    pend_d          = pend_q;
    space_d         = space_q;
    sent_d          = sent_q;
    cmd_push_o      = 1'b0;
    cmd_o.newline   = 1'b0;
    cmd_o.gap       = GapNone;
    cmd_o.pattern   = letter_pattern(idx);
    if (sent_q && space_q) begin
      cmd_o.gap = GapWord;
    end else if (pend_q) begin
      cmd_o.gap = GapLetter;
    end
    if (accept) begin
      if (action_i) begin
        cmd_push_o    = 1'b1;
        cmd_o.newline = 1'b1;
        pend_d        = 1'b0;
        space_d       = 1'b0;
        sent_d        = 1'b0;
      end else if (char_code_i == CharSpace) begin
        space_d = 1'b1;
        pend_d  = 1'b0;
      end else if (is_letter) begin
        cmd_push_o = 1'b1;
        space_d    = 1'b0;
        sent_d     = 1'b1;
        pend_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      space_q <= 1'b0;
      sent_q  <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      space_q <= space_d;
      sent_q  <= sent_d;
    end
  end

endmodule

// File: design/mck_cmd_fifo.sv
module mck_cmd_fifo
  import mck_pkg::*;
#(
  parameter int unsigned Depth = MckCmdDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  cmd_t             mem_q [Depth];
  logic [AddrW-1:0] wr_q, wr_d;
  logic [AddrW-1:0] rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastAddr) ? '0 : wr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastAddr) ? '0 : rd_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: design/mck_back.sv
module mck_back
  import mck_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_empty_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic       led_on_o,
  output logic [2:0] duration_units_o,
  output logic [2:0] text_symbol_o,
  output logic       last_o
);

  back_state_e state_q, state_d;
  logic [15:0] pat_q, pat_d;
  gap_e        gap_q, gap_d;
  logic        out_valid_q, out_valid_d;
  logic        led_q, led_d;
  logic [2:0]  dur_q, dur_d;
  sym_e        sym_q, sym_d;
  logic        last_q, last_d;
  logic        load_ok;
  logic        seg_emit;
  logic        seg_led;
  logic [2:0]  seg_dur;
  sym_e        seg_sym;
  logic        seg_last;

  assign load_ok = !out_valid_q || pop_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (!cmd_empty_i) begin
          if (cmd_i.newline) begin
            state_d = BkNewline;
          end else if (cmd_i.gap != GapNone) begin
            state_d = BkGap;
          end else begin
            state_d = BkElems;
          end
        end
      end
      BkGap: begin
        if (load_ok) begin
          state_d = BkElems;
        end
      end
      BkElems: begin
        if (load_ok && pat_q == '0) begin
          state_d = BkIdle;
        end
      end
      BkNewline: begin
        if (load_ok) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    pat_d     = pat_q;
    gap_d     = gap_q;
    seg_emit  = 1'b0;
    seg_led   = 1'b0;
    seg_dur   = DurNone;
    seg_sym   = SymNone;
    seg_last  = 1'b0;
    case (state_q)
      BkIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          pat_d     = cmd_i.pattern;
          gap_d     = cmd_i.gap;
        end
      end
      BkGap: begin
        seg_emit = load_ok;
        if (gap_q == GapWord) begin
          seg_dur = DurWord;
          seg_sym = SymTwoSpaces;
        end else begin
          seg_dur = DurLetter;
          seg_sym = SymOneSpace;
        end
      end
      BkElems: begin
        seg_emit = load_ok;
        if (pat_q == '0) begin
          seg_last = 1'b1;
        end else if (pat_q[15:13] == 3'b111) begin
          seg_led = 1'b1;
          seg_dur = DurDash;
          seg_sym = SymDash;
          if (load_ok) begin
            pat_d = {pat_q[12:0], 3'b000};
          end
        end else if (pat_q[15]) begin
          seg_led = 1'b1;
          seg_dur = DurDot;
          seg_sym = SymDot;
          if (load_ok) begin
            pat_d = {pat_q[14:0], 1'b0};
          end
        end else begin
          seg_dur = DurDot;
          if (load_ok) begin
            pat_d = {pat_q[14:0], 1'b0};
          end
        end
      end
      BkNewline: begin
        seg_emit = load_ok;
        seg_sym  = SymNewline;
        seg_last = 1'b1;
      end
      default: begin
        seg_emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    led_d       = led_q;
    dur_d       = dur_q;
    sym_d       = sym_q;
    last_d      = last_q;
    if (seg_emit) begin
      out_valid_d = 1'b1;
      led_d       = seg_led;
      dur_d       = seg_dur;
      sym_d       = seg_sym;
      last_d      = seg_last;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q  <= pat_d;
    gap_q  <= gap_d;
    led_q  <= led_d;
    dur_q  <= dur_d;
    sym_q  <= sym_d;
    last_q <= last_d;
  end

  assign empty_o          = !out_valid_q;
  assign led_on_o         = led_q;
  assign duration_units_o = dur_q;
  assign text_symbol_o    = sym_q;
  assign last_o           = last_q;

endmodule

// File: design/mck_checker.sv
module mck_checker
  import mck_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       led_on_o,
  input logic [2:0] duration_units_o,
  input logic [2:0] text_symbol_o,
  input logic       last_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(text_symbol_o) && $stable(duration_units_o)
      && $stable(led_on_o) && $stable(last_o))
    else $error("held result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && text_symbol_o == SymNewline |-> last_o && !led_on_o
      && duration_units_o == DurNone)
    else $error("malformed newline segment");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && led_on_o |-> !last_o
      && (duration_units_o == DurDot || duration_units_o == DurDash))
    else $error("malformed lit segment");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && last_o && text_symbol_o != SymNewline |-> !led_on_o
      && duration_units_o == DurNone && text_symbol_o == SymNone)
    else $error("malformed closing segment");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && text_symbol_o == SymTwoSpaces |-> !led_on_o && !last_o
      && duration_units_o == DurWord)
    else $error("malformed word gap");

endmodule

bind morse_code_keyer_unit mck_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .led_on_o         (led_on_o),
  .duration_units_o (duration_units_o),
  .text_symbol_o    (text_symbol_o),
  .last_o           (last_o)
);
